// File: rtl/vp8hc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vp8hc_pkg
// Status codes, tag bytes and offsets shared by the lossy WebP head checker.
// ----------------------------------------------------------------------------
package vp8hc_pkg;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_CONTAINER = 3'd1,
		ST_SHORT     = 3'd2,
		ST_START     = 3'd3,
		ST_NOT_KEY   = 3'd4,
		ST_PROFILE   = 3'd5,
		ST_HIDDEN    = 3'd6,
		ST_PARTITION = 3'd7
	} status_t;

	localparam logic [31:0] MIN_LENGTH      = 32'd10;
	localparam logic [31:0] RIFF_MIN_LENGTH = 32'd30;
	localparam logic [31:0] RIFF_MIN_SIZE   = 32'd12;

	// "RIF" little endian, then the closing 'F'
	localparam logic [23:0] RIFF_TAG3 = 24'h464952;
	localparam logic [7:0]  RIFF_LAST = 8'h46;

	// byte offsets in the container head
	localparam logic [4:0] OFF_RIFF_TAG   = 5'd3;
	localparam logic [4:0] OFF_RIFF_SIZE  = 5'd7;
	localparam logic [4:0] OFF_TAGS       = 5'd8;
	localparam logic [4:0] OFF_CHUNK      = 5'd16;
	localparam logic [4:0] OFF_CHUNK_LAST = 5'd19;
	localparam logic [4:0] FRAME_BASE     = 5'd20;

	// byte offsets in the frame data
	localparam logic [4:0] R_START     = 5'd3;
	localparam logic [4:0] R_START_END = 5'd5;
	localparam logic [4:0] R_SIZE      = 5'd6;
	localparam logic [4:0] R_SIZE1     = 5'd7;
	localparam logic [4:0] R_SIZE2     = 5'd8;
	localparam logic [4:0] R_LAST      = 5'd9;

	// "WEBP" then "VP8 "
	function automatic logic [7:0] tag_byte(input logic [2:0] idx);
		logic [7:0] v;
		case (idx)
			3'd0:    v = 8'h57;
			3'd1:    v = 8'h45;
			3'd2:    v = 8'h42;
			3'd3:    v = 8'h50;
			3'd4:    v = 8'h56;
			3'd5:    v = 8'h50;
			3'd6:    v = 8'h38;
			default: v = 8'h20;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] start_code(input logic [1:0] idx);
		logic [7:0] v;
		case (idx)
			2'd0:    v = 8'h9d;
			2'd1:    v = 8'h01;
			default: v = 8'h2a;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// File: rtl/webp_vp8_header_checker_core.sv
`default_nettype none
// Lossy WebP head checker. Takes one file byte per transfer, starting with the
// byte that carries start_of_header, and gives one result per parse: a status
// code and, for status 0, the 14-bit frame width and height. A new byte can be
// taken every cycle unless the input stalls; a byte passes an input register and
// one pass of compare logic, and its result is then registered in the output
// register. While a result waits under out_stall, the byte in the input register
// holds and the input stalls. The widest path is the 32-bit chunk size against
// RIFF size minus 12 compare on the last container byte.
// ----------------------------------------------------------------------------
// webp_vp8_header_checker_core
// Byte-serial parse of the optional RIFF/WEBP/VP8 container and the VP8 frame head.
// ----------------------------------------------------------------------------
module webp_vp8_header_checker_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic                start_of_header,
	input  wire logic [7:0]          data_byte,
	input  wire logic [31:0]         total_length,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output vp8hc_pkg::status_t       status,
	output logic [13:0]              frame_width,
	output logic [13:0]              frame_height
);
	import vp8hc_pkg::*;

	// input register
	logic        vld_s1;
	logic        sof_s1;
	logic [7:0]  byte_s1;
	logic [31:0] len_s1;

	// parse state
	logic [4:0]  off_q;
	logic        cont_q;
	logic        done_q;
	logic        long_q;
	logic [31:0] riff_q;
	logic [31:0] chunk_q;
	logic [23:0] tag_q;
	logic [13:0] wid_q;
	logic [7:0]  hlo_q;

	// result register
	logic        out_vld_q;
	status_t     st_q;
	logic [13:0] w_q;
	logic [13:0] h_q;

	logic go;

	// state as seen by the byte in the input register (start clears it, but loads chunk and long from the length)
	logic [4:0]  c_off;
	logic        c_cont;
	logic        c_done;
	logic        c_long;
	logic [31:0] c_riff;
	logic [31:0] c_chunk;
	logic [23:0] c_tag;
	logic        len_short;

	logic [4:0]  n_off;
	logic        n_cont;
	logic        n_done;
	logic [31:0] n_riff;
	logic [31:0] n_chunk;
	logic [23:0] n_tag;
	logic [13:0] n_wid;
	logic [7:0]  n_hlo;
	logic        res;
	status_t     res_st;
	logic [13:0] res_w;
	logic [13:0] res_h;
	logic        in_frame;
	logic [4:0]  r;

	assign go       = vld_s1 && !(out_vld_q && out_stall);
	assign in_stall = vld_s1 && out_vld_q && out_stall;

	always_comb begin
		c_off     = sof_s1 ? 5'd0 : off_q;
		c_cont    = sof_s1 ? 1'b0 : cont_q;
		c_done    = sof_s1 ? 1'b0 : done_q;
		c_long    = sof_s1 ? (len_s1 >= RIFF_MIN_LENGTH) : long_q;
		c_riff    = sof_s1 ? 32'd0 : riff_q;
		c_chunk   = sof_s1 ? len_s1 : chunk_q;
		c_tag     = sof_s1 ? 24'd0 : tag_q;
		len_short = sof_s1 && (len_s1 < MIN_LENGTH);
	end

	always_comb begin
		n_off    = c_off;
		n_cont   = c_cont;
		n_done   = c_done;
		n_riff   = c_riff;
		n_chunk  = c_chunk;
		n_tag    = c_tag;
		n_wid    = wid_q;
		n_hlo    = hlo_q;
		res      = 1'b0;
		res_st   = ST_OK;
		res_w    = 14'd0;
		res_h    = 14'd0;
		in_frame = 1'b0;
		r        = c_off;

		if (len_short) begin
			res    = 1'b1;
			res_st = ST_SHORT;
			n_done = 1'b1;
		end else if (!c_done) begin
			n_off = c_off + 5'd1;
			if (!c_cont) begin
				if (c_off == OFF_RIFF_TAG && c_long && c_tag == RIFF_TAG3 &&
				    byte_s1 == RIFF_LAST) begin
					n_cont = 1'b1;
					n_tag  = 24'd0;
				end else begin
					in_frame = 1'b1;
					r        = c_off;
				end
			end else if (c_off < OFF_TAGS) begin
				n_riff = {byte_s1, c_riff[31:8]};
				if (c_off == OFF_RIFF_SIZE && n_riff < RIFF_MIN_SIZE) begin
					res    = 1'b1;
					res_st = ST_CONTAINER;
					n_done = 1'b1;
				end
			end else if (c_off < OFF_CHUNK) begin
				if (byte_s1 != tag_byte(3'(c_off - OFF_TAGS))) begin
					res    = 1'b1;
					res_st = ST_CONTAINER;
					n_done = 1'b1;
				end
			end else if (c_off < FRAME_BASE) begin
				n_chunk = {byte_s1, c_chunk[31:8]};
				if (c_off == OFF_CHUNK_LAST &&
				    (n_chunk == 32'd0 || n_chunk > c_riff - RIFF_MIN_SIZE)) begin
					res    = 1'b1;
					res_st = ST_CONTAINER;
					n_done = 1'b1;
				end
			end else begin
				in_frame = 1'b1;
				r        = c_off - FRAME_BASE;
			end

			if (in_frame) begin
				if (r < R_START) begin
					n_tag[{r[1:0], 3'b000} +: 8] = byte_s1;
				end else if (r < R_SIZE) begin
					if (byte_s1 != start_code(2'(r - R_START))) begin
						res    = 1'b1;
						res_st = ST_START;
						n_done = 1'b1;
					end else if (r == R_START_END) begin
						// frame tag checks, in priority order
						if (c_tag[0]) begin
							res    = 1'b1;
							res_st = ST_NOT_KEY;
							n_done = 1'b1;
						end else if (c_tag[3]) begin
							res    = 1'b1;
							res_st = ST_PROFILE;
							n_done = 1'b1;
						end else if (!c_tag[4]) begin
							res    = 1'b1;
							res_st = ST_HIDDEN;
							n_done = 1'b1;
						end else if ({13'd0, c_tag[23:5]} >= c_chunk) begin
							res    = 1'b1;
							res_st = ST_PARTITION;
							n_done = 1'b1;
						end
					end
				end else if (r == R_SIZE) begin
					n_wid[7:0] = byte_s1;
				end else if (r == R_SIZE1) begin
					n_wid[13:8] = byte_s1[5:0];
				end else if (r == R_SIZE2) begin
					n_hlo = byte_s1;
				end else if (r == R_LAST) begin
					res    = 1'b1;
					res_st = ST_OK;
					res_w  = wid_q;
					res_h  = {byte_s1[5:0], hlo_q};
					n_done = 1'b1;
				end
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			sof_s1  <= start_of_header;
			byte_s1 <= data_byte;
			len_s1  <= total_length;
		end
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q   <= 5'd0;
			cont_q  <= 1'b0;
			done_q  <= 1'b1;
			long_q  <= 1'b0;
			riff_q  <= 32'd0;
			chunk_q <= 32'd0;
			tag_q   <= 24'd0;
		end else if (go) begin
			off_q   <= n_off;
			cont_q  <= n_cont;
			done_q  <= n_done;
			long_q  <= c_long;
			riff_q  <= n_riff;
			chunk_q <= n_chunk;
			tag_q   <= n_tag;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			wid_q <= n_wid;
			hlo_q <= n_hlo;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (go) begin
			out_vld_q <= res;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && res) begin
			st_q <= res_st;
			w_q  <= res_w;
			h_q  <= res_h;
		end
	end

	assign out_valid    = out_vld_q;
	assign status       = st_q;
	assign frame_width  = w_q;
	assign frame_height = h_q;

	// a result only appears after a byte went through the parse logic
	a_result_from_byte: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(go))
		else $error("result without a parsed byte");

	// failed parses report no frame size
	a_fail_zero_size: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> frame_width == 14'd0 && frame_height == 14'd0)
		else $error("frame size on a failed parse");

	// an open parse never runs past the end of the frame head
	a_raw_offset: assert property (@(posedge clk) disable iff (!arst_n)
		!done_q && !cont_q |-> off_q <= R_LAST)
		else $error("raw parse past frame head");

	a_cont_offset: assert property (@(posedge clk) disable iff (!arst_n)
		!done_q && cont_q |-> off_q <= FRAME_BASE + R_LAST)
		else $error("container parse past frame head");

endmodule
`default_nettype wire
